>>> design/voice_issue_scheduler_defines.svh
// Assertion macros shared by the checker of the voice issue scheduler.
// Depends on nothing; include by bare file name.
`ifndef VOICE_ISSUE_SCHEDULER_DEFINES_SVH
`define VOICE_ISSUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/vis_pkg.sv
// Shared types, constants and helpers of the voice issue scheduler.
// Used by the slot cell, the top level and the checker; depends on nothing.
package vis_pkg;

  localparam int VIS_SLOTS  = 8;
  localparam int VIS_IDX_W  = (VIS_SLOTS > 1) ? $clog2(VIS_SLOTS) : 1;
  localparam int VIS_CNT_W  = $clog2(VIS_SLOTS + 1);
  localparam int VIS_TIME_W = 48;
  localparam logic [VIS_TIME_W-1:0] VIS_TIME_MAX = '1;

  localparam int VIS_CFG_ADDR_W = 3;
  localparam int VIS_CFG_DATA_W = 16;
  localparam logic [VIS_CFG_ADDR_W-1:0] CFG_VOICES_TOTAL  = 3'd0;
  localparam logic [VIS_CFG_ADDR_W-1:0] CFG_FRAMES_EACH   = 3'd1;
  localparam logic [VIS_CFG_ADDR_W-1:0] CFG_PREP_INTERVAL = 3'd2;
  localparam logic [VIS_CFG_ADDR_W-1:0] CFG_REISSUE_GAP   = 3'd3;
  localparam logic [VIS_CFG_ADDR_W-1:0] CFG_DRAIN_DELAY   = 3'd4;

  // Result beat, lowest field last so that cycle_number sits in bit 0 up.
  typedef struct packed {
    logic        done_res;
    logic [47:0] idle_total;
    logic [47:0] stalls_total;
    logic [47:0] samples_total;
    logic [5:0]  max_occupied;
    logic [5:0]  occupied_now;
    logic        dsp_idle;
    logic        frontend_stalled;
    logic [5:0]  retired_now;
    logic [4:0]  issued_entry;
    logic        issued;
    logic [47:0] cycle_number;
  } vis_result_t;

  localparam int VIS_RES_W = $bits(vis_result_t);
  localparam int VIS_OUT_W = ((VIS_RES_W + 7) / 8) * 8;
  localparam int VIS_IN_W  = 8;

  // Broadcast from the top level to every cell of the slot row.
  typedef struct packed {
    logic [VIS_TIME_W-1:0] cyc;
    logic [15:0]           frames_each;
    logic [9:0]            reissue_gap;
    logic [9:0]            drain_delay;
    logic [VIS_IDX_W-1:0]  rr_ptr;
    logic                  use_hi;
    logic                  tick_en;
    logic                  clear;
  } vis_cell_ctl_t;

  // Carried from each cell to its right-hand neighbor.
  typedef struct packed {
    logic                 alloc_req;
    logic                 hi_found;
    logic                 lo_found;
    logic [VIS_CNT_W-1:0] busy_cnt;
    logic [VIS_CNT_W-1:0] ret_cnt;
  } vis_chain_t;

  function automatic logic [VIS_TIME_W-1:0] sat_add(input logic [VIS_TIME_W-1:0] a,
                                                    input logic [9:0] b);
    logic [VIS_TIME_W:0] s;
    s = {1'b0, a} + {{(VIS_TIME_W - 9){1'b0}}, b};
    return s[VIS_TIME_W] ? VIS_TIME_MAX : s[VIS_TIME_W-1:0];
  endfunction

endpackage

>>> design/vis_slot_cell.sv
// One work entry of the scheduler: retire, allocate and issue logic for its slot.
// Depends on vis_pkg; cells are chained left to right by the top level.
module vis_slot_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [vis_pkg::VIS_IDX_W-1:0] cell_idx,
  input  vis_pkg::vis_cell_ctl_t        ctl,
  input  vis_pkg::vis_chain_t           chain_in,
  output vis_pkg::vis_chain_t           chain_out,
  output logic                          busy_o,
  output logic                          go_o
);

  logic                           busy_r, busy_nxt;
  logic [15:0]                    frames_r, frames_nxt;
  logic [vis_pkg::VIS_TIME_W-1:0] issue_t_r, issue_t_nxt;
  logic [vis_pkg::VIS_TIME_W-1:0] retire_t_r, retire_t_nxt;

  logic                           retire, free_slot, alloc_here;
  logic                           busy_a, elig, in_hi, take_hi, take_lo;
  logic [15:0]                    frames_a, frames_inc;
  logic [vis_pkg::VIS_TIME_W-1:0] issue_a, retire_a;

  always_comb begin
    retire     = busy_r && (frames_r >= ctl.frames_each) && (ctl.cyc >= retire_t_r);
    free_slot  = !busy_r || retire;
    alloc_here = chain_in.alloc_req && free_slot;

    // Entry state after retirement and allocation, before the issue step.
    busy_a   = (busy_r && !retire) || alloc_here;
    frames_a = (retire || alloc_here) ? 16'd0 : frames_r;
    issue_a  = alloc_here ? vis_pkg::sat_add(ctl.cyc, 10'd1) :
               (retire ? '0 : issue_t_r);
    retire_a = (retire || alloc_here) ? '0 : retire_t_r;

    elig    = busy_a && (frames_a < ctl.frames_each) && (ctl.cyc >= issue_a);
    in_hi   = (cell_idx >= ctl.rr_ptr);
    take_hi = elig && in_hi && !chain_in.hi_found;
    take_lo = elig && !chain_in.lo_found;
    go_o    = ctl.use_hi ? take_hi : take_lo;

    frames_inc   = frames_a + 16'd1;
    busy_nxt     = busy_a;
    frames_nxt   = go_o ? frames_inc : frames_a;
    issue_t_nxt  = go_o ? vis_pkg::sat_add(ctl.cyc, ctl.reissue_gap) : issue_a;
    retire_t_nxt = (go_o && (frames_inc == ctl.frames_each)) ?
                   vis_pkg::sat_add(ctl.cyc, ctl.drain_delay) : retire_a;

    chain_out.alloc_req = chain_in.alloc_req && !free_slot;
    chain_out.hi_found  = chain_in.hi_found || (elig && in_hi);
    chain_out.lo_found  = chain_in.lo_found || elig;
    chain_out.busy_cnt  = chain_in.busy_cnt + vis_pkg::VIS_CNT_W'(busy_a);
    chain_out.ret_cnt   = chain_in.ret_cnt + vis_pkg::VIS_CNT_W'(retire);
  end

  assign busy_o = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.clear) begin
      busy_r <= 1'b0;
    end else if (ctl.tick_en) begin
      busy_r <= busy_nxt;
    end
  end

  // Payload is only looked at while the entry is busy.
  always_ff @(posedge clk) begin
    if (ctl.tick_en) begin
      frames_r   <= frames_nxt;
      issue_t_r  <= issue_t_nxt;
      retire_t_r <= retire_t_nxt;
    end
  end

endmodule

>>> design/voice_issue_scheduler.sv
// Channel  Dir  Beat contents
// in_      in   tdata[0] restart, tdata[7:1] zero
// out_     out  tdata: cycle_number .. done_res (see port comment), 224 bits
// cfg_     in   write enable, register index, 16-bit write data
//
// One tick is processed per clock unless the output stalls: the slot cells settle
// retirement, allocation into the lowest free slot and round-robin issue together.
// The result register frees in_tready whenever it is empty or out_tready is high,
// so a stalled output holds the input back without losing a beat.
// rst_n is synchronous; reset sets every config register to 1 and clears the run.
// Top level of the voice issue scheduler; depends on vis_pkg and vis_slot_cell.
module voice_issue_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [vis_pkg::VIS_IN_W-1:0]       in_tdata,   // restart, zero fill
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cycle_number, issued, issued_entry, retired_now, frontend_stalled, dsp_idle,
  // occupied_now, max_occupied, samples_total, stalls_total, idle_total,
  // done_res, zero fill
  output logic [vis_pkg::VIS_OUT_W-1:0]      out_tdata,
  input  logic                               cfg_we,
  input  logic [vis_pkg::VIS_CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vis_pkg::VIS_CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOTS = vis_pkg::VIS_SLOTS;
  localparam int IDX_W = vis_pkg::VIS_IDX_W;
  localparam int TW    = vis_pkg::VIS_TIME_W;

  logic [15:0] vtotal_r, frames_each_r;
  logic [9:0]  prep_int_r, gap_r, drain_r;

  logic [TW-1:0]             tick_r, tick_nxt;
  logic [15:0]               vprep_r, vprep_nxt, vret_r, vret_nxt;
  logic [IDX_W-1:0]          rr_r, rr_nxt;
  logic [TW-1:0]             prep_due_r, prep_due_nxt;
  logic [vis_pkg::VIS_CNT_W-1:0] peak_r, peak_nxt;
  logic [TW-1:0]             samples_r, samples_nxt, stalls_r, stalls_nxt;
  logic [TW-1:0]             idles_r, idles_nxt;

  logic                      out_valid_r;
  vis_pkg::vis_result_t      res, res_r;

  logic                      accept, restart, done_now, tick_en, alloc_en;
  logic                      any_go, stalled;
  vis_pkg::vis_cell_ctl_t    ctl;
  vis_pkg::vis_chain_t       chain [SLOTS+1];
  logic [SLOTS-1:0]          busy_vec, go_vec;
  logic [IDX_W-1:0]          winner;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];
  assign done_now  = (vret_r >= vtotal_r);
  assign tick_en   = accept && !restart && !done_now;
  assign alloc_en  = (vprep_r < vtotal_r) && (tick_r >= prep_due_r);

  always_comb begin
    ctl.cyc         = tick_r;
    ctl.frames_each = frames_each_r;
    ctl.reissue_gap = gap_r;
    ctl.drain_delay = drain_r;
    ctl.rr_ptr      = rr_r;
    ctl.use_hi      = chain[SLOTS].hi_found;
    ctl.tick_en     = tick_en;
    ctl.clear       = accept && restart;
  end

  assign chain[0] = '{alloc_req: alloc_en, hi_found: 1'b0, lo_found: 1'b0,
                      busy_cnt: '0, ret_cnt: '0};

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    vis_slot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .ctl       (ctl),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .busy_o    (busy_vec[g]),
      .go_o      (go_vec[g])
    );
  end

  // At most one cell issues, so an OR of the indexes encodes the winner.
  always_comb begin
    winner = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (go_vec[i]) begin
        winner = winner | IDX_W'(i);
      end
    end
  end

  always_comb begin
    any_go  = |go_vec;
    stalled = alloc_en && chain[SLOTS].alloc_req;

    tick_nxt     = vis_pkg::sat_add(tick_r, 10'd1);
    vret_nxt     = vret_r + 16'(chain[SLOTS].ret_cnt);
    vprep_nxt    = vprep_r;
    prep_due_nxt = prep_due_r;
    stalls_nxt   = stalls_r;
    if (alloc_en && !stalled) begin
      vprep_nxt    = vprep_r + 16'd1;
      prep_due_nxt = vis_pkg::sat_add(tick_r, prep_int_r);
    end
    if (stalled) begin
      stalls_nxt = vis_pkg::sat_add(stalls_r, 10'd1);
    end
    peak_nxt    = (chain[SLOTS].busy_cnt > peak_r) ? chain[SLOTS].busy_cnt : peak_r;
    samples_nxt = any_go ? vis_pkg::sat_add(samples_r, 10'd1) : samples_r;
    idles_nxt   = any_go ? idles_r : vis_pkg::sat_add(idles_r, 10'd1);
    rr_nxt      = rr_r;
    if (any_go) begin
      rr_nxt = (winner == IDX_W'(SLOTS - 1)) ? '0 : winner + IDX_W'(1);
    end

    res = '0;
    if (restart) begin
      res.done_res = (vtotal_r == 16'd0);
    end else if (done_now) begin
      res.cycle_number  = (tick_r == '0) ? '0 : tick_r - TW'(1);
      res.occupied_now  = 6'($countones(busy_vec));
      res.max_occupied  = 6'(peak_r);
      res.samples_total = samples_r;
      res.stalls_total  = stalls_r;
      res.idle_total    = idles_r;
      res.done_res      = 1'b1;
    end else begin
      res.cycle_number     = tick_r;
      res.issued           = any_go;
      res.issued_entry     = 5'(winner);
      res.retired_now      = 6'(chain[SLOTS].ret_cnt);
      res.frontend_stalled = stalled;
      res.dsp_idle         = !any_go;
      res.occupied_now     = 6'(chain[SLOTS].busy_cnt);
      res.max_occupied     = 6'(peak_nxt);
      res.samples_total    = samples_nxt;
      res.stalls_total     = stalls_nxt;
      res.idle_total       = idles_nxt;
      res.done_res         = (vret_nxt >= vtotal_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtotal_r      <= 16'd1;
      frames_each_r <= 16'd1;
      prep_int_r    <= 10'd1;
      gap_r         <= 10'd1;
      drain_r       <= 10'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        vis_pkg::CFG_VOICES_TOTAL:  vtotal_r      <= cfg_wdata;
        vis_pkg::CFG_FRAMES_EACH:   frames_each_r <= cfg_wdata;
        vis_pkg::CFG_PREP_INTERVAL: prep_int_r    <= cfg_wdata[9:0];
        vis_pkg::CFG_REISSUE_GAP:   gap_r         <= cfg_wdata[9:0];
        vis_pkg::CFG_DRAIN_DELAY:   drain_r       <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && restart)) begin
      tick_r     <= '0;
      vprep_r    <= '0;
      vret_r     <= '0;
      rr_r       <= '0;
      prep_due_r <= (!rst_n) ? TW'(1) : TW'(prep_int_r);
      peak_r     <= '0;
      samples_r  <= '0;
      stalls_r   <= '0;
      idles_r    <= '0;
    end else if (tick_en) begin
      tick_r     <= tick_nxt;
      vprep_r    <= vprep_nxt;
      vret_r     <= vret_nxt;
      rr_r       <= rr_nxt;
      prep_due_r <= prep_due_nxt;
      peak_r     <= peak_nxt;
      samples_r  <= samples_nxt;
      stalls_r   <= stalls_nxt;
      idles_r    <= idles_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(vis_pkg::VIS_OUT_W - vis_pkg::VIS_RES_W){1'b0}}, res_r};

endmodule

>>> design/vis_checker.sv
// Port-level checker of the voice issue scheduler, bound to the top level.
// Depends on vis_pkg and voice_issue_scheduler_defines.svh.
`include "voice_issue_scheduler_defines.svh"

module vis_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [vis_pkg::VIS_OUT_W-1:0] out_tdata
);

  vis_pkg::vis_result_t r;

  assign r = out_tdata[vis_pkg::VIS_RES_W-1:0];

  `VIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `VIS_ASSERT_NOW(a_issue_not_idle, clk, rst_n, out_tvalid && r.issued, !r.dsp_idle, "issue and idle flagged together")
  `VIS_ASSERT_NOW(a_entry_zero, clk, rst_n, out_tvalid && !r.issued, r.issued_entry == 5'd0, "entry reported without an issue")
  `VIS_ASSERT_NOW(a_peak_bound, clk, rst_n, out_tvalid, r.occupied_now <= r.max_occupied, "occupancy above its peak")

endmodule

bind voice_issue_scheduler vis_checker u_vis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
